// File: rtl/core/umpf_pkg.sv
// umpf_pkg: shared types, constants and the packet length table for the ump framer
// used by umpf_front, umpf_queue, umpf_back and the top level
package umpf_pkg;

    // string payload bytes kept per reply never exceed this
    localparam int MAX_STRING_BYTES = 255;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // header compare masks and field positions
    localparam logic [31:0] CMD_HDR_MASK = 32'hffff0000;
    localparam logic [31:0] STR_HDR_MASK = 32'hf3ff0000;
    localparam int          FMT_LSB      = 26;
    localparam int          STATUS_LSB   = 16;

    // configuration register indexes
    localparam int          CFG_IDX_W            = 4;
    localparam logic [3:0]  REG_RESPONSE_MODE    = 4'd0;
    localparam logic [3:0]  REG_EXPECTED_HEADER  = 4'd1;
    localparam logic [3:0]  REG_STRING_CAPACITY  = 4'd2;
    localparam logic [3:0]  REG_NAME_STATUS_CODE = 4'd3;
    localparam logic [9:0]  NAME_STATUS_RESET    = 10'd18;

    // response modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_CMD  = 2'd1;
    localparam logic [1:0] MODE_STR  = 2'd2;

    // string format codes that close the reply
    localparam logic [1:0] FMT_COMPLETE = 2'd0;
    localparam logic [1:0] FMT_END      = 2'd3;

    // string payload starts at these byte offsets
    localparam logic [3:0] STR_OFF_STD  = 4'd2;
    localparam logic [3:0] STR_OFF_NAME = 4'd3;
    localparam logic [4:0] PKT_BYTES    = 5'd16;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_CMD       = 2'd1,
        EV_STR_BYTE  = 2'd2,
        EV_STR_EMPTY = 2'd3
    } event_t;

    // one completed packet, classified
    typedef struct packed {
        logic [3:0][31:0] words;
        logic [2:0]       packet_words;
        event_t           ev;
        logic [3:0]       byte_off;
        logic [3:0]       byte_cnt;
        logic             finished;
    } entry_t;

    // one result transaction
    typedef struct packed {
        logic             packet_done;
        event_t           ev;
        logic [3:0][31:0] words;
        logic [2:0]       packet_words;
        logic [7:0]       string_byte;
        logic             reply_finished;
        logic             last;
    } result_t;

    // packet length in words by message type
    function automatic logic [2:0] pkt_len(input logic [3:0] mt);
        logic [2:0] len;
        unique case (mt)
            4'h0, 4'h1, 4'h2, 4'h6, 4'h7: len = 3'd1;
            4'h3, 4'h4, 4'h8, 4'h9, 4'ha: len = 3'd2;
            4'hb, 4'hc:                   len = 3'd3;
            default:                      len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/core/umpf_front.sv
// umpf_front: word intake, packet assembly, reply classification and config registers
// depends on umpf_pkg
module umpf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [umpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output umpf_pkg::entry_t              q_entry
);

    logic [1:0]  mode_reg, mode_next;
    logic [31:0] exp_hdr_reg, exp_hdr_next;
    logic [7:0]  cap_reg, cap_next;
    logic [9:0]  name_code_reg, name_code_next;
    logic [2:0]  words_left_reg, words_left_next;
    logic [2:0]  words_held_reg, words_held_next;
    logic        awaiting_reg, awaiting_next;
    logic [7:0]  str_cnt_reg, str_cnt_next;
    logic [31:0] store_reg [4];

    logic             accept;
    logic             cfg_wr;
    logic [2:0]       left_cur;
    logic [2:0]       held_cur;
    logic [2:0]       held_new;
    logic [2:0]       left_new;
    logic             pkt_done;
    logic [3:0][31:0] pkt;
    logic [31:0]      hdr;
    logic             match_cmd;
    logic             match_str;
    logic [1:0]       fmt;
    logic [3:0]       off;
    logic [3:0]       avail;
    logic [7:0]       lim;
    logic [7:0]       room;
    logic [3:0]       nbytes;

    // a register write takes the cycle, words wait for it
    assign s_ready   = !q_full && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        left_cur = (words_left_reg == 3'd0) ? umpf_pkg::pkt_len(s_word[31:28]) : words_left_reg;
        held_cur = (words_left_reg == 3'd0) ? 3'd0 : words_held_reg;
        held_new = held_cur + 3'd1;
        left_new = left_cur - 3'd1;
        pkt_done = (left_new == 3'd0);
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < held_new) begin
                pkt[i] = (2'(i) == held_cur[1:0]) ? s_word : store_reg[i];
            end else begin
                pkt[i] = 32'd0;
            end
        end
    end

    // classification of the completed packet
    always_comb begin
        hdr       = pkt[0];
        fmt       = hdr[umpf_pkg::FMT_LSB +: 2];
        match_cmd = awaiting_reg && (mode_reg == umpf_pkg::MODE_CMD)
                    && ((hdr & umpf_pkg::CMD_HDR_MASK) == exp_hdr_reg);
        match_str = awaiting_reg && (mode_reg == umpf_pkg::MODE_STR)
                    && ((hdr & umpf_pkg::STR_HDR_MASK) == exp_hdr_reg)
                    && (held_new == 3'd4);
        off   = (hdr[umpf_pkg::STATUS_LSB +: 10] == name_code_reg)
                ? umpf_pkg::STR_OFF_NAME : umpf_pkg::STR_OFF_STD;
        avail = 4'(umpf_pkg::PKT_BYTES - {1'b0, off});
        lim   = (int'(cap_reg) > umpf_pkg::MAX_STRING_BYTES)
                ? 8'(umpf_pkg::MAX_STRING_BYTES) : cap_reg;
        room  = lim - str_cnt_reg;
        if (str_cnt_reg >= lim) begin
            nbytes = 4'd0;
        end else if (room < {4'd0, avail}) begin
            nbytes = room[3:0];
        end else begin
            nbytes = avail;
        end
    end

    always_comb begin
        q_entry.words        = pkt;
        q_entry.packet_words = held_new;
        q_entry.byte_off     = off;
        q_entry.byte_cnt     = 4'd0;
        q_entry.finished     = 1'b0;
        q_entry.ev           = umpf_pkg::EV_NONE;
        if (match_cmd) begin
            q_entry.ev       = umpf_pkg::EV_CMD;
            q_entry.finished = 1'b1;
        end else if (match_str) begin
            q_entry.byte_cnt = nbytes;
            q_entry.ev       = (nbytes == 4'd0) ? umpf_pkg::EV_STR_EMPTY
                                                : umpf_pkg::EV_STR_BYTE;
            q_entry.finished = (fmt == umpf_pkg::FMT_COMPLETE) || (fmt == umpf_pkg::FMT_END);
        end
    end

    assign q_push = accept && pkt_done;

    always_comb begin
        mode_next       = mode_reg;
        exp_hdr_next    = exp_hdr_reg;
        cap_next        = cap_reg;
        name_code_next  = name_code_reg;
        words_left_next = words_left_reg;
        words_held_next = words_held_reg;
        awaiting_next   = awaiting_reg;
        str_cnt_next    = str_cnt_reg;
        if (cfg_wr) begin
            unique case (cfg_index)
                umpf_pkg::REG_RESPONSE_MODE: begin
                    mode_next     = cfg_data[1:0];
                    str_cnt_next  = 8'd0;
                    awaiting_next = (cfg_data[1:0] == umpf_pkg::MODE_CMD)
                                    || (cfg_data[1:0] == umpf_pkg::MODE_STR);
                end
                umpf_pkg::REG_EXPECTED_HEADER:  exp_hdr_next   = cfg_data;
                umpf_pkg::REG_STRING_CAPACITY:  cap_next       = cfg_data[7:0];
                umpf_pkg::REG_NAME_STATUS_CODE: name_code_next = cfg_data[9:0];
                default: ;
            endcase
        end else if (accept) begin
            words_left_next = left_new;
            words_held_next = held_new;
            if (pkt_done) begin
                if (match_cmd) begin
                    awaiting_next = 1'b0;
                end else if (match_str) begin
                    str_cnt_next = str_cnt_reg + {4'd0, nbytes};
                    if (q_entry.finished) begin
                        awaiting_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= umpf_pkg::MODE_NONE;
            exp_hdr_reg    <= 32'd0;
            cap_reg        <= 8'd0;
            name_code_reg  <= umpf_pkg::NAME_STATUS_RESET;
            words_left_reg <= 3'd0;
            words_held_reg <= 3'd0;
            awaiting_reg   <= 1'b0;
            str_cnt_reg    <= 8'd0;
        end else begin
            mode_reg       <= mode_next;
            exp_hdr_reg    <= exp_hdr_next;
            cap_reg        <= cap_next;
            name_code_reg  <= name_code_next;
            words_left_reg <= words_left_next;
            words_held_reg <= words_held_next;
            awaiting_reg   <= awaiting_next;
            str_cnt_reg    <= str_cnt_next;
        end
    end

    // packet words, no reset needed
    always_ff @(posedge aclk) begin
        if (accept && !cfg_wr) begin
            store_reg[held_cur[1:0]] <= s_word;
        end
    end

endmodule

// File: rtl/core/umpf_queue.sv
// umpf_queue: short queue of classified packets between front and back
// depends on umpf_pkg
module umpf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  umpf_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output umpf_pkg::entry_t head
);

    umpf_pkg::entry_t                 mem_reg [umpf_pkg::QUEUE_DEPTH];
    logic [umpf_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [umpf_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [umpf_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                             do_push;
    logic                             do_pop;

    localparam logic [umpf_pkg::QPTR_W-1:0] PTR_LAST = umpf_pkg::QPTR_W'(umpf_pkg::QUEUE_DEPTH - 1);
    localparam logic [umpf_pkg::QCNT_W-1:0] CNT_FULL = umpf_pkg::QCNT_W'(umpf_pkg::QUEUE_DEPTH);
    localparam logic [umpf_pkg::QCNT_W-1:0] CNT_ONE  = umpf_pkg::QCNT_W'(1);

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_ONE;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/umpf_back.sv
// umpf_back: expands each queued packet into results, one per cycle unless stalled
// depends on umpf_pkg
module umpf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  umpf_pkg::entry_t  q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output umpf_pkg::result_t m_result
);

    umpf_pkg::entry_t  cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [3:0]        k_reg, k_next;
    logic              out_valid_reg, out_valid_next;
    umpf_pkg::result_t out_reg;

    logic              out_free;
    logic              fire;
    logic              is_last;
    logic              load;
    logic [3:0]        n_res;
    logic [3:0]        idx;
    logic [31:0]       sel_word;
    umpf_pkg::result_t res;

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = cur_valid_reg && out_free;
    assign n_res    = (cur_reg.byte_cnt == 4'd0) ? 4'd1 : cur_reg.byte_cnt;
    assign is_last  = ((k_reg + 4'd1) == n_res);
    assign load     = !cur_valid_reg || (fire && is_last);
    assign q_pop    = load && q_not_empty;

    // byte of the packet at offset plus step, most significant first
    always_comb begin
        idx      = cur_reg.byte_off + k_reg;
        sel_word = cur_reg.words[idx[3:2]];
        res.packet_done    = 1'b1;
        res.ev             = cur_reg.ev;
        res.words          = cur_reg.words;
        res.packet_words   = cur_reg.packet_words;
        res.string_byte    = 8'd0;
        if (cur_reg.ev == umpf_pkg::EV_STR_BYTE) begin
            res.string_byte = 8'(sel_word >> {~idx[1:0], 3'b000});
        end
        res.last           = is_last;
        res.reply_finished = is_last && cur_reg.finished;
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
            k_next         = k_reg + 4'd1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            cur_valid_next = q_not_empty;
            cur_next       = q_head;
            k_next         = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            k_reg         <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

// File: rtl/core/ump_packet_framer_reply_matcher.sv
// ump_packet_framer_reply_matcher: top level of the ump packet framer and reply matcher
// depends on umpf_pkg, umpf_front, umpf_queue, umpf_back
// throughput: one word per cycle in while the queue has room and no register write is pending;
// one result per cycle out while m_ready is high; a string packet gives up to 14 results, so
// the back end's single result register sets the sustained rate under string load
// reset: aresetn synchronous active low, clears framing state, wait flag, string count and
// config registers (name status code returns to 18); the packet store is not cleared
module ump_packet_framer_reply_matcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    // word input
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [31:0]                    s_word,
    // result output
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_packet_done,
    output logic [1:0]                     m_event_res,
    output logic [31:0]                    m_word_0,
    output logic [31:0]                    m_word_1,
    output logic [31:0]                    m_word_2,
    output logic [31:0]                    m_word_3,
    output logic [2:0]                     m_packet_words,
    output logic [7:0]                     m_string_byte,
    output logic                           m_reply_finished,
    output logic                           m_last,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [umpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    // front to queue
    logic              q_push;
    logic              q_full;
    umpf_pkg::entry_t  q_in;
    // queue to back
    logic              q_pop;
    logic              q_not_empty;
    umpf_pkg::entry_t  q_head;
    umpf_pkg::result_t m_result;

    // front: assembles words into packets, matches replies, owns the registers
    umpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // two-entry queue lets intake run while the back end streams string bytes
    umpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // back: one result transaction per cycle unless stalled, into a registered output
    umpf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    // unpack the result onto its ports
    assign m_packet_done    = m_result.packet_done;
    assign m_event_res      = m_result.ev;
    assign m_word_0         = m_result.words[0];
    assign m_word_1         = m_result.words[1];
    assign m_word_2         = m_result.words[2];
    assign m_word_3         = m_result.words[3];
    assign m_packet_words   = m_result.packet_words;
    assign m_string_byte    = m_result.string_byte;
    assign m_reply_finished = m_result.reply_finished;
    assign m_last           = m_result.last;

endmodule

// File: tb/umpf_check_pkg.sv
// umpf_check_pkg: result predictor and scoreboard for the ump packet framer testbench
// depends on umpf_pkg for the result struct, event codes, masks and register indexes
package umpf_check_pkg;

    import umpf_pkg::*;

    // packet length in words, indexed by message type
    localparam logic [2:0] WORDS_BY_TYPE [16] = '{
        3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4
    };

    class ump_reply_predictor;

        // register copies
        logic [1:0]  mode;
        logic [31:0] expected_hdr;
        logic [7:0]  capacity;
        logic [9:0]  name_code;

        // framing and reply state
        logic [2:0]  words_left;
        logic [2:0]  words_held;
        logic [31:0] store [4];
        bit          awaiting;
        logic [7:0]  string_count;

        result_t     pending_results [$];
        int          mismatches;

        function new();
            mode         = MODE_NONE;
            expected_hdr = '0;
            capacity     = '0;
            name_code    = NAME_STATUS_RESET;
            words_left   = '0;
            words_held   = '0;
            foreach (store[i]) store[i] = '0;
            awaiting     = 1'b0;
            string_count = '0;
            mismatches   = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
            case (index)
                REG_RESPONSE_MODE: begin
                    mode         = data[1:0];
                    string_count = '0;
                    awaiting     = (mode == MODE_CMD) || (mode == MODE_STR);
                end
                REG_EXPECTED_HEADER:  expected_hdr = data;
                REG_STRING_CAPACITY:  capacity     = data[7:0];
                REG_NAME_STATUS_CODE: name_code    = data[9:0];
                default: ;
            endcase
        endfunction

        function result_t make_result(event_t ev, logic [7:0] str_byte);
            result_t r;
            r = '0;
            r.packet_done = 1'b1;
            r.ev          = ev;
            for (int i = 0; i < 4; i++)
                r.words[i] = (i < words_held) ? store[i] : 32'h0;
            r.packet_words = words_held;
            r.string_byte  = str_byte;
            return r;
        endfunction

        // one accepted word; queues whatever results it causes
        function void take_word(logic [31:0] w);
            result_t     batch [$];
            logic [31:0] hdr;
            int          limit;
            int          first_byte;
            bit          wait_done;
            if (words_left == 3'd0) begin
                words_left = WORDS_BY_TYPE[w[31:28]];
                words_held = 3'd0;
            end
            store[words_held[1:0]] = w;
            words_held = words_held + 3'd1;
            words_left = words_left - 3'd1;
            if (words_left != 3'd0)
                return;

            hdr       = store[0];
            wait_done = 1'b0;
            if (awaiting && mode == MODE_CMD && (hdr & CMD_HDR_MASK) == expected_hdr) begin
                batch.push_back(make_result(EV_CMD, 8'h00));
                awaiting  = 1'b0;
                wait_done = 1'b1;
            end else if (awaiting && mode == MODE_STR && words_held == 3'd4 &&
                         (hdr & STR_HDR_MASK) == expected_hdr) begin
                first_byte = (hdr[STATUS_LSB +: 10] == name_code) ? int'(STR_OFF_NAME)
                                                                   : int'(STR_OFF_STD);
                limit = int'(capacity);
                if (limit > MAX_STRING_BYTES)
                    limit = MAX_STRING_BYTES;
                for (int o = first_byte; o < int'(PKT_BYTES) && int'(string_count) < limit;
                     o++) begin
                    batch.push_back(make_result(EV_STR_BYTE,
                                                8'(store[o / 4] >> (8 * (3 - o % 4)))));
                    string_count = string_count + 8'd1;
                end
                if (batch.size() == 0)
                    batch.push_back(make_result(EV_STR_EMPTY, 8'h00));
                if (hdr[FMT_LSB +: 2] == FMT_COMPLETE || hdr[FMT_LSB +: 2] == FMT_END) begin
                    awaiting  = 1'b0;
                    wait_done = 1'b1;
                end
            end else begin
                batch.push_back(make_result(EV_NONE, 8'h00));
            end

            batch[batch.size() - 1].reply_finished = wait_done;
            batch[batch.size() - 1].last           = 1'b1;
            foreach (batch[i]) pending_results.push_back(batch[i]);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // one accepted result against the oldest expectation
        function void compare_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual event %0d word_0 %h",
                         $time, got.ev, got.words[0]);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            check_field("packet_done", want.packet_done, got.packet_done);
            check_field("event_res", want.ev, got.ev);
            for (int i = 0; i < 4; i++)
                check_field($sformatf("word_%0d", i), want.words[i], got.words[i]);
            check_field("packet_words", want.packet_words, got.packet_words);
            check_field("string_byte", want.string_byte, got.string_byte);
            check_field("reply_finished", want.reply_finished, got.reply_finished);
            check_field("last", want.last, got.last);
        endfunction

    endclass

endpackage

// File: tb/testbench.sv
// testbench: drives ump_packet_framer_reply_matcher with directed and random packet words
// depends on umpf_pkg, umpf_check_pkg and the rtl of the framer
module testbench;

    import umpf_pkg::*;
    import umpf_check_pkg::*;

    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on any channel
    localparam int RANDOM_WORDS = 130;

    // codes not named by the package
    localparam logic [1:0]           MODE_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 4'hf;

    // message types whose packets are four words long
    localparam logic [3:0] FOUR_WORD_TYPES [4] = '{4'h5, 4'hd, 4'he, 4'hf};

    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } reg_write_t;

    // block ports, all inputs known from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [31:0]          s_word    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_packet_done;
    logic [1:0]           m_event_res;
    logic [31:0]          m_word_0;
    logic [31:0]          m_word_1;
    logic [31:0]          m_word_2;
    logic [31:0]          m_word_3;
    logic [2:0]           m_packet_words;
    logic [7:0]           m_string_byte;
    logic                 m_reply_finished;
    logic                 m_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    ump_reply_predictor reply_predictor;
    logic [31:0]        word_plan [$];
    reg_write_t         reg_plan [$];
    bit                 tx_calm = 1'b0;
    bit                 rx_calm = 1'b0;
    int                 rx_wait = 0;
    int                 rx_draw;
    int                 quiet_cycles = 0;
    int                 words_sent = 0;
    result_t            seen_result;

    always #6 aclk = ~aclk;

    ump_packet_framer_reply_matcher dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_word           (s_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_done    (m_packet_done),
        .m_event_res      (m_event_res),
        .m_word_0         (m_word_0),
        .m_word_1         (m_word_1),
        .m_word_2         (m_word_2),
        .m_word_3         (m_word_3),
        .m_packet_words   (m_packet_words),
        .m_string_byte    (m_string_byte),
        .m_reply_finished (m_reply_finished),
        .m_last           (m_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // result side: check every transaction, then hold ready low for a drawn stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            seen_result = {m_packet_done, m_event_res, m_word_3, m_word_2, m_word_1, m_word_0,
                           m_packet_words, m_string_byte, m_reply_finished, m_last};
            reply_predictor.compare_result(seen_result);
            rx_draw = rx_calm ? 0 : $urandom_range(0, 5);
            m_ready <= (rx_draw == 0);
            rx_wait <= rx_draw;
        end else if (!m_ready) begin
            // count the stall down, raise ready on its last cycle
            if (rx_wait <= 1)
                m_ready <= 1'b1;
            rx_wait <= (rx_wait > 0) ? rx_wait - 1 : 0;
        end
    end

    // watchdog: too long without any transaction means the block hung
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // queue a packet: header word then random body words per its message type
    task automatic plan_packet(input logic [31:0] hdr);
        word_plan.push_back(hdr);
        for (int i = 1; i < int'(WORDS_BY_TYPE[hdr[31:28]]); i++)
            word_plan.push_back($urandom());
    endtask

    task automatic plan_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        reg_write_t wr;
        wr.index = index;
        wr.data  = data;
        reg_plan.push_back(wr);
    endtask

    // send the planned words; valid stays up between back-to-back transactions
    task automatic send_words();
        int gap;
        while (word_plan.size() > 0) begin
            gap = tx_calm ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_word  <= word_plan.pop_front();
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            reply_predictor.take_word(s_word);
            words_sent++;
        end
        s_valid <= 1'b0;
    endtask

    // register writes, only issued while the block is idle
    task automatic write_regs();
        reg_write_t wr;
        while (reg_plan.size() > 0) begin
            wr = reg_plan.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= wr.index;
            cfg_data  <= wr.data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            reply_predictor.write_reg(wr.index, wr.data);
        end
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every expected result is back, then lets a
    // trailing word that completes nothing work its way through
    task automatic settle();
        while (reply_predictor.outstanding() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [1:0]  mode;
        logic [31:0] hdr;
        logic [9:0]  status;
        int          pick;
        int          packets;

        reply_predictor = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // out of reset nothing is awaited: all-zero one-word packet, all-ones four-word packet
        word_plan = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff};
        send_words();
        settle();

        // command reply captured once, the repeat after the wait ended is plain
        plan_reg(REG_RESPONSE_MODE, {30'h0, MODE_CMD});
        plan_reg(REG_EXPECTED_HEADER, 32'h20ab_0000);
        plan_reg(REG_NAME_STATUS_CODE, 32'h0000_03ff);
        write_regs();
        word_plan = '{32'h20ab_1234, 32'h20ab_5678};
        send_words();
        settle();

        // block-name string: payload from byte three, start packet then end packet
        plan_reg(REG_RESPONSE_MODE, {30'h0, MODE_STR});
        plan_reg(REG_EXPECTED_HEADER, 32'hf012_0000);
        plan_reg(REG_STRING_CAPACITY, 32'd255);
        plan_reg(REG_NAME_STATUS_CODE, 32'd18);
        write_regs();
        word_plan = '{32'hf412_4142, 32'h4344_4546, 32'h4748_494a, 32'h4b4c_4d4e,
                      32'hfc12_5051, 32'h5253_5455, 32'h5657_5859, 32'h5a5b_5c5d};
        send_words();
        settle();

        // payload from byte two, capacity runs out, then a packet with no byte stored
        plan_reg(REG_RESPONSE_MODE, {30'h0, MODE_STR});
        plan_reg(REG_EXPECTED_HEADER, 32'hd007_0000);
        plan_reg(REG_STRING_CAPACITY, 32'd5);
        plan_reg(REG_NAME_STATUS_CODE, 32'd0);
        write_regs();
        plan_packet(32'hd407_0102);
        plan_packet(32'hdc07_0304);
        send_words();
        settle();

        // string header match on a two-word packet stays plain
        plan_reg(REG_RESPONSE_MODE, {30'h0, MODE_STR});
        plan_reg(REG_EXPECTED_HEADER, 32'h3000_0000);
        write_regs();
        word_plan = '{32'h3000_1111, 32'h2222_3333};
        send_words();
        settle();

        // reserved mode awaits nothing; a write to an unused index changes nothing
        plan_reg(REG_RESPONSE_MODE, {30'h0, MODE_RESERVED});
        plan_reg(REG_EXPECTED_HEADER, 32'h1000_0000);
        plan_reg(REG_STRING_CAPACITY, 32'd0);
        plan_reg(REG_UNUSED, $urandom());
        write_regs();
        word_plan = '{32'h1000_abcd};
        send_words();
        settle();

        // random phases: new settings, then a burst of packets, in command and string modes mostly built to match
        while (words_sent < RANDOM_WORDS) begin
            settle();
            pick = $urandom_range(0, 19);
            mode = (pick < 7) ? MODE_CMD : (pick < 16) ? MODE_STR :
                   (pick < 18) ? MODE_NONE : MODE_RESERVED;
            status = 10'($urandom());
            pick = $urandom_range(0, 19);
            if (pick == 0)
                hdr = 32'h0000_0000;
            else if (pick == 1)
                hdr = 32'hffff_ffff;
            else if (mode == MODE_STR)
                hdr = {FOUR_WORD_TYPES[$urandom_range(0, 3)], 2'b00, status, 16'h0};
            else
                hdr = {16'($urandom()), 16'h0};

            // upper data bits are random to show the registers keep only their width
            plan_reg(REG_RESPONSE_MODE, {30'($urandom()), mode});
            plan_reg(REG_EXPECTED_HEADER, hdr);
            if ($urandom_range(0, 9) < 6) begin
                pick = $urandom_range(0, 9);
                plan_reg(REG_STRING_CAPACITY, {24'($urandom()),
                         (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 40))});
            end
            if ($urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, 5);
                plan_reg(REG_NAME_STATUS_CODE, {22'($urandom()),
                         (pick == 0) ? 10'd0 : (pick == 1) ? 10'h3ff :
                         (pick < 4) ? status : 10'($urandom())});
            end
            if ($urandom_range(0, 7) == 0)
                plan_reg(4'(REG_NAME_STATUS_CODE + $urandom_range(1, 12)), $urandom());
            write_regs();

            // some phases run with no idling on either side
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);

            packets = $urandom_range(2, 6);
            for (int k = 0; k < packets; k++) begin
                pick = $urandom_range(0, 19);
                if (pick < 11 && mode == MODE_CMD)
                    plan_packet({hdr[31:16], 16'($urandom())});
                else if (pick < 11 && mode == MODE_STR)
                    plan_packet((hdr & STR_HDR_MASK) | {4'h0, 2'($urandom()), 26'h0} |
                                {16'h0, 16'($urandom())});
                else if (pick < 17)
                    plan_packet($urandom());
                else
                    word_plan.push_back($urandom());  // lone word, breaks the framing
            end
            send_words();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        settle();
        if (reply_predictor.mismatches == 0 && reply_predictor.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
